### rtl/bfm_pkg.sv
// Shared constants, codes, types and helpers for the Brainfuck machine.
package bfm_pkg;

  localparam int MEM_DEPTH = 65536;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int DEPTH_W   = ADDR_W + 1;

  localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(MEM_DEPTH - 1);

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_RESTART = 2'd1;
  localparam logic [1:0] MODE_EXEC    = 2'd2;

  localparam logic [1:0] ST_RUN       = 2'd0;
  localparam logic [1:0] ST_HALT      = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;

  localparam logic [7:0] OP_NUL   = 8'h00;
  localparam logic [7:0] OP_DOT   = 8'h2E;
  localparam logic [7:0] OP_COMMA = 8'h2C;
  localparam logic [7:0] OP_LBR   = 8'h5B;
  localparam logic [7:0] OP_RBR   = 8'h5D;
  localparam logic [7:0] OP_LT    = 8'h3C;
  localparam logic [7:0] OP_GT    = 8'h3E;
  localparam logic [7:0] OP_MINUS = 8'h2D;
  localparam logic [7:0] OP_PLUS  = 8'h2B;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == ADDR_MAX) ? '0 : ADDR_W'(a + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] a);
    return (a == '0) ? ADDR_MAX : ADDR_W'(a - 1'b1);
  endfunction

endpackage

### rtl/bfm_mem.sv
// Shared program and tape byte memory: one write port, one registered read port.
module bfm_mem
  import bfm_pkg::*;
(
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/brainfuck_machine_step.sv
// Top level of the Brainfuck machine: sequencer around the shared byte memory.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_mode, in_address, in_data_byte
//   out     | output    | out_valid/out_stall | out_out_valid, out_out_byte,
//           |           |                     | out_input_taken, out_status
//   cfg     | input     | cfg_wr_en           | cfg_wr_data (program_length)
//
// Load, restart, no-op and halted execute pass from S_IDLE through S_POST to the output register.
// Execute of < > or a skipped byte adds S_FETCH; . , + - and untaken brackets add S_FETCH and S_CELL.
// A bracket scan adds an S_SCAN step for each byte walked, through the single memory read port.
// After reset a clearing pass writes zero to all 65536 entries, one per cycle;
// in_stall stays high during it. cfg writes are taken at any time.
// A result waits in the output register while out_stall is high.
module brainfuck_machine_step
  import bfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_out_valid,
  output logic [7:0]  out_out_byte,
  output logic        out_input_taken,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_CELL  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  ip_r, ip_nxt;
  logic [ADDR_W-1:0]  tp_r, tp_nxt;
  logic [1:0]         rs_r, rs_nxt;
  logic [15:0]        pl_r;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [7:0]         op_r, op_nxt;
  logic [ADDR_W-1:0]  scan_r, scan_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] depth_new;
  logic               fwd_r, fwd_nxt;
  logic [7:0]         db_r, db_nxt;
  logic               res_ov_r, res_ov_nxt;
  logic [7:0]         res_byte_r, res_byte_nxt;
  logic               res_taken_r, res_taken_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ov_r, out_ov_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_taken_r, out_taken_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  mem_wr_t            wr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [7:0]         rd_q;
  logic               in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  bfm_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_q)
  );

  always_comb begin
    state_nxt      = state_r;
    ip_nxt         = ip_r;
    tp_nxt         = tp_r;
    rs_nxt         = rs_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    scan_nxt       = scan_r;
    depth_nxt      = depth_r;
    depth_new      = depth_r;
    fwd_nxt        = fwd_r;
    db_nxt         = db_r;
    res_ov_nxt     = res_ov_r;
    res_byte_nxt   = res_byte_r;
    res_taken_nxt  = res_taken_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_ov_nxt     = out_ov_r;
    out_byte_nxt   = out_byte_r;
    out_taken_nxt  = out_taken_r;
    out_status_nxt = out_status_r;
    wr             = '0;
    rd_addr        = ip_r;

    unique case (state_r)
      S_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_r;
        wr.data = 8'h00;
        clr_nxt = ADDR_W'(clr_r + 1'b1);
        if (clr_r == ADDR_MAX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          res_ov_nxt    = 1'b0;
          res_byte_nxt  = 8'h00;
          res_taken_nxt = 1'b0;
          db_nxt        = in_data_byte;
          state_nxt     = S_POST;
          case (in_mode)
            MODE_LOAD: begin
              wr.en   = 1'b1;
              wr.addr = ADDR_W'(in_address);
              wr.data = in_data_byte;
            end
            MODE_RESTART: begin
              ip_nxt  = '0;
              tp_nxt  = ADDR_W'(pl_r);
              rs_nxt  = ST_RUN;
              wr.en   = 1'b1;
              wr.addr = ADDR_W'(pl_r);
              wr.data = 8'h00;
            end
            MODE_EXEC: begin
              if (rs_r == ST_RUN) begin
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end

      S_FETCH: begin
        rd_addr   = tp_r;
        op_nxt    = rd_q;
        state_nxt = S_POST;
        case (rd_q) inside
          OP_NUL: rs_nxt = ST_HALT;
          OP_LT: begin
            tp_nxt = wrap_dec(tp_r);
            ip_nxt = wrap_inc(ip_r);
          end
          OP_GT: begin
            tp_nxt = wrap_inc(tp_r);
            ip_nxt = wrap_inc(ip_r);
          end
          OP_DOT, OP_COMMA, OP_PLUS, OP_MINUS, OP_LBR, OP_RBR: state_nxt = S_CELL;
          default: ip_nxt = wrap_inc(ip_r);
        endcase
      end

      S_CELL: begin
        state_nxt = S_POST;
        ip_nxt    = wrap_inc(ip_r);
        case (op_r)
          OP_DOT: begin
            res_ov_nxt   = 1'b1;
            res_byte_nxt = rd_q;
          end
          OP_COMMA: begin
            wr.en         = 1'b1;
            wr.addr       = tp_r;
            wr.data       = db_r;
            res_taken_nxt = 1'b1;
          end
          OP_PLUS: begin
            wr.en   = 1'b1;
            wr.addr = tp_r;
            wr.data = 8'(rd_q + 1'b1);
          end
          OP_MINUS: begin
            wr.en   = 1'b1;
            wr.addr = tp_r;
            wr.data = 8'(rd_q - 1'b1);
          end
          OP_LBR: begin
            if (rd_q == 8'h00) begin
              ip_nxt = ip_r;
              if (ip_r == ADDR_MAX) begin
                rs_nxt = ST_UNMATCHED;
              end else begin
                scan_nxt  = wrap_inc(ip_r);
                rd_addr   = scan_nxt;
                depth_nxt = DEPTH_W'(1);
                fwd_nxt   = 1'b1;
                state_nxt = S_SCAN;
              end
            end
          end
          OP_RBR: begin
            if (rd_q != 8'h00) begin
              ip_nxt = ip_r;
              if (ip_r == '0) begin
                rs_nxt = ST_UNMATCHED;
              end else begin
                scan_nxt  = wrap_dec(ip_r);
                rd_addr   = scan_nxt;
                depth_nxt = DEPTH_W'(1);
                fwd_nxt   = 1'b0;
                state_nxt = S_SCAN;
              end
            end
          end
          default: ;
        endcase
      end

      S_SCAN: begin
        if ((fwd_r && rd_q == OP_LBR) || (!fwd_r && rd_q == OP_RBR)) begin
          depth_new = DEPTH_W'(depth_r + 1'b1);
        end else if ((fwd_r && rd_q == OP_RBR) || (!fwd_r && rd_q == OP_LBR)) begin
          depth_new = DEPTH_W'(depth_r - 1'b1);
        end
        depth_nxt = depth_new;
        if (depth_new == '0) begin
          ip_nxt    = wrap_inc(scan_r);
          state_nxt = S_POST;
        end else if ((fwd_r && scan_r == ADDR_MAX) || (!fwd_r && scan_r == '0)) begin
          rs_nxt    = ST_UNMATCHED;
          state_nxt = S_POST;
        end else begin
          scan_nxt = fwd_r ? wrap_inc(scan_r) : wrap_dec(scan_r);
          rd_addr  = scan_nxt;
        end
      end

      S_POST: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_ov_nxt     = res_ov_r;
          out_byte_nxt   = res_byte_r;
          out_taken_nxt  = res_taken_r;
          out_status_nxt = rs_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ip_r        <= '0;
      tp_r        <= '0;
      rs_r        <= ST_RUN;
      pl_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ip_r        <= ip_nxt;
      tp_r        <= tp_nxt;
      rs_r        <= rs_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        pl_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    scan_r       <= scan_nxt;
    depth_r      <= depth_nxt;
    fwd_r        <= fwd_nxt;
    db_r         <= db_nxt;
    res_ov_r     <= res_ov_nxt;
    res_byte_r   <= res_byte_nxt;
    res_taken_r  <= res_taken_nxt;
    out_ov_r     <= out_ov_nxt;
    out_byte_r   <= out_byte_nxt;
    out_taken_r  <= out_taken_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_out_valid   = out_ov_r;
  assign out_out_byte    = out_byte_r;
  assign out_input_taken = out_taken_r;
  assign out_status      = out_status_r;

endmodule

### rtl/bfm_checker.sv
// Port-level assertions for the Brainfuck machine, bound to the top level.
module bfm_checker
  import bfm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_out_valid,
  input logic [7:0]  out_out_byte,
  input logic        out_input_taken,
  input logic [1:0]  out_status
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte) && $stable(out_status))
    else $error("stalled result transaction changed");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_byte == 8'h00)
    else $error("output byte set without a dot instruction");

  a_one_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_out_valid && out_input_taken) && out_status != 2'd3)
    else $error("inconsistent result fields");

  a_io_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_out_valid || out_input_taken) |-> out_status == ST_RUN)
    else $error("I/O reported while halted");

endmodule

bind brainfuck_machine_step bfm_checker u_bfm_checker (.*);

### tb/brainfuck_machine_step_test.sv
// Self-checking testbench for brainfuck_machine_step: directed table, then random programs.
`timescale 1ns / 100ps

module brainfuck_machine_step_test;
  import bfm_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam logic [7:0] OP_OTHER = 8'h78;
  localparam int RANDOM_ITEMS = 700;
  localparam int unsigned CYCLE_LIMIT = 250_000_000;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_out;
    logic       taken;
    logic [1:0] status;
  } bf_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        typed;
    bf_result_t  want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_NOP;
  logic [15:0] in_address = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_input_taken;
  logic [1:0]  out_status;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  logic [7:0]        mem_img [MEM_DEPTH];
  logic [ADDR_W-1:0] code_ptr;
  logic [ADDR_W-1:0] cell_ptr;
  logic [1:0]        run_st;
  logic [15:0]       tape_base;

  bf_result_t pending_results [$];
  stim_row_t  stim_tab [$];
  int err_count = 0;
  int items_sent = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  brainfuck_machine_step dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_address      (in_address),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_out_valid   (out_out_valid),
    .out_out_byte    (out_out_byte),
    .out_input_taken (out_input_taken),
    .out_status      (out_status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bf_result_t machine_step(input logic [1:0] m, input logic [15:0] a,
                                              input logic [7:0] d);
    bf_result_t        r;
    logic [7:0]        op;
    logic [7:0]        tape_byte;
    logic [ADDR_W-1:0] j;
    int                depth;
    logic              stopped;
    r = '0;
    stopped = 1'b0;
    case (m)
      MODE_LOAD: mem_img[a] = d;
      MODE_RESTART: begin
        code_ptr = '0;
        cell_ptr = tape_base;
        mem_img[cell_ptr] = 8'h00;
        run_st = ST_RUN;
      end
      MODE_EXEC: if (run_st == ST_RUN) begin
        op = mem_img[code_ptr];
        tape_byte = mem_img[cell_ptr];
        case (op)
          OP_NUL: begin
            run_st = ST_HALT;
            stopped = 1'b1;
          end
          OP_DOT: begin
            r.byte_valid = 1'b1;
            r.byte_out = tape_byte;
          end
          OP_COMMA: begin
            mem_img[cell_ptr] = d;
            r.taken = 1'b1;
          end
          OP_PLUS:  mem_img[cell_ptr] = tape_byte + 8'd1;
          OP_MINUS: mem_img[cell_ptr] = tape_byte - 8'd1;
          OP_LT:    cell_ptr = cell_ptr - 1'b1;
          OP_GT:    cell_ptr = cell_ptr + 1'b1;
          OP_LBR: if (tape_byte == 8'h00) begin
            depth = 1;
            j = code_ptr;
            while (depth != 0 && !stopped) begin
              if (j == ADDR_MAX) begin
                run_st = ST_UNMATCHED;
                stopped = 1'b1;
              end else begin
                j = j + 1'b1;
                if (mem_img[j] == OP_LBR) depth++;
                else if (mem_img[j] == OP_RBR) depth--;
              end
            end
            if (!stopped) code_ptr = j;
          end
          OP_RBR: if (tape_byte != 8'h00) begin
            depth = 1;
            j = code_ptr;
            while (depth != 0 && !stopped) begin
              if (j == '0) begin
                run_st = ST_UNMATCHED;
                stopped = 1'b1;
              end else begin
                j = j - 1'b1;
                if (mem_img[j] == OP_RBR) depth++;
                else if (mem_img[j] == OP_LBR) depth--;
              end
            end
            if (!stopped) code_ptr = j;
          end
          default: ;
        endcase
        if (!stopped) code_ptr = code_ptr + 1'b1;
      end
      default: ;
    endcase
    r.status = run_st;
    return r;
  endfunction

  function automatic stim_row_t stim(input row_kind_t kind, input logic [1:0] mode,
                                     input logic [15:0] addr, input logic [7:0] data,
                                     input logic typed, input bf_result_t want);
    stim_row_t s;
    s.kind = kind;
    s.mode = mode;
    s.addr = addr;
    s.data = data;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic bf_result_t quiet(input logic [1:0] st);
    return {1'b0, 8'h00, 1'b0, st};
  endfunction

  task automatic send_item(input logic [1:0] m, input logic [15:0] a, input logic [7:0] d,
                           input logic typed, input bf_result_t want);
    bf_result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_address <= a;
    in_data_byte <= d;
    do @(posedge clk); while (in_stall);
    r = machine_step(m, a, d);
    pending_results.push_back(typed ? want : r);
    if (m != MODE_NOP) items_sent++;
  endtask

  task automatic send_noise();
    logic [7:0] b;
    b = 8'($urandom);
    case ($urandom_range(2))
      0: send_item(MODE_NOP, 16'($urandom), b, 1'b0, '0);
      1: begin
        if (b == OP_LBR || b == OP_RBR) b = OP_OTHER;
        send_item(MODE_LOAD, 16'($urandom), b, 1'b0, '0);
      end
      default: send_item(MODE_RESTART, 16'($urandom), b, 1'b0, '0);
    endcase
  endtask

  task automatic write_plen(input logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    tape_base = v;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : result_check
    bf_result_t got;
    bf_result_t want;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = {out_out_valid, out_out_byte, out_input_taken, out_status};
        if (pending_results.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected transaction valid=%0b byte=%02h taken=%0b status=%0d",
                     $realtime, got.byte_valid, got.byte_out, got.taken, got.status);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (err_count < 10)
              $display({"%0t: mismatch expected valid=%0b byte=%02h taken=%0b status=%0d",
                        " got valid=%0b byte=%02h taken=%0b status=%0d"}, $realtime,
                       want.byte_valid, want.byte_out, want.taken, want.status,
                       got.byte_valid, got.byte_out, got.taken, got.status);
            err_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("brainfuck_machine_step_test: errors");
    $finish;
  end

  initial begin : main_flow
    int unsigned prog_len;
    int unsigned steps;
    int unsigned open;
    int          rnd_base;
    int          phase;
    logic [7:0]  b;
    logic [15:0] plen;
    logic [7:0]  prog_q [$];

    foreach (mem_img[i]) mem_img[i] = 8'h00;
    code_ptr = '0;
    cell_ptr = '0;
    run_st = ST_RUN;
    tape_base = '0;

    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_NOP, 16'hFFFF, 8'hFF, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd0, OP_PLUS, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd1, OP_COMMA, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd2, OP_DOT, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd3, OP_MINUS, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd4, OP_GT, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd5, OP_LT, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd6, OP_OTHER, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd7, OP_RBR, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_CFG, MODE_NOP, 16'hFFFF, 8'h00, 1'b0, '0));
    stim_tab.push_back(stim(ROW_ITEM, MODE_RESTART, 16'h0000, 8'h00, 1'b1, quiet(ST_RUN)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b1, quiet(ST_RUN)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'hFF, 1'b1,
                            {1'b0, 8'h00, 1'b1, ST_RUN}));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b1,
                            {1'b1, 8'hFF, 1'b0, ST_RUN}));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h5A5A, 8'h5A, 1'b0, '0));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'hA5A5, 8'hA5, 1'b0, '0));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b0, '0));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b0, '0));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b1, quiet(ST_UNMATCHED)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'hFFFF, 8'hFF, 1'b1, quiet(ST_UNMATCHED)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd0, OP_LBR, 1'b1, quiet(ST_UNMATCHED)));
    stim_tab.push_back(stim(ROW_CFG, MODE_NOP, 16'd3, 8'h00, 1'b0, '0));
    stim_tab.push_back(stim(ROW_ITEM, MODE_RESTART, 16'hFFFF, 8'hFF, 1'b1, quiet(ST_RUN)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b0, '0));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_LOAD, 16'd7, OP_PLUS, 1'b1, quiet(ST_HALT)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_RESTART, 16'h0000, 8'h00, 1'b1, quiet(ST_RUN)));
    stim_tab.push_back(stim(ROW_ITEM, MODE_EXEC, 16'h0000, 8'h00, 1'b1, quiet(ST_UNMATCHED)));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 31;
    recv_stall_pct = 60;
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG)
        write_plen(stim_tab[i].addr);
      else
        send_item(stim_tab[i].mode, stim_tab[i].addr, stim_tab[i].data,
                  stim_tab[i].typed, stim_tab[i].want);
    end

    rnd_base = items_sent;
    phase = 0;
    while (items_sent - rnd_base < RANDOM_ITEMS) begin
      if (items_sent - rnd_base < RANDOM_ITEMS / 3) begin
        send_gap_pct = 31;
        recv_stall_pct = 60;
      end else if (items_sent - rnd_base < 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct = 60;
        recv_stall_pct = 31;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end

      prog_len = $urandom_range(3, 40);
      case ($urandom_range(7))
        0:       plen = 16'($urandom);
        1:       plen = 16'($urandom_range(prog_len));
        default: plen = 16'(prog_len + $urandom_range(24));
      endcase
      if (phase == 0) plen = '0;
      write_plen(plen);

      prog_q.delete();
      open = 0;
      repeat (prog_len) begin
        case ($urandom_range(15))
          0, 1, 2: b = OP_PLUS;
          3, 4:    b = OP_MINUS;
          5, 6:    b = OP_GT;
          7:       b = OP_LT;
          8, 9:    b = OP_DOT;
          10:      b = OP_COMMA;
          11, 12:  b = (open < 4) ? OP_LBR : OP_PLUS;
          13, 14:  b = (open > 0) ? OP_RBR : OP_DOT;
          default: begin
            b = 8'($urandom);
            if (b == OP_LBR || b == OP_RBR) b = OP_OTHER;
          end
        endcase
        if (b == OP_LBR) open++;
        if (b == OP_RBR) open--;
        prog_q.push_back(b);
      end
      repeat (open) prog_q.push_back(OP_RBR);

      foreach (prog_q[k]) begin
        if ($urandom_range(9) == 0) send_noise();
        send_item(MODE_LOAD, 16'(k), prog_q[k], 1'b0, '0);
      end
      send_item(MODE_RESTART, 16'($urandom), 8'($urandom), 1'b0, '0);
      steps = $urandom_range(15, 45);
      repeat (steps) begin
        if ($urandom_range(19) == 0) send_noise();
        send_item(MODE_EXEC, 16'($urandom), 8'($urandom), 1'b0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0)
      $display("brainfuck_machine_step_test: clean");
    else
      $display("brainfuck_machine_step_test: errors");
    $finish;
  end

endmodule
